// File: hw/rtl/utf8tc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8tc_pkg
// Shared types and constants for the UTF-8 transcoder.
// ----------------------------------------------------------------------------
package utf8tc_pkg;

    localparam int unsigned CodeWidth = 21;
    localparam int unsigned RoomWidth = 3;

    // register indexes
    localparam logic RegDirection = 1'b0;

    // direction codes
    localparam logic DirDecode = 1'b0;
    localparam logic DirEncode = 1'b1;

    // lead byte markers
    localparam logic [7:0] Lead2 = 8'hC0;
    localparam logic [7:0] Lead3 = 8'hE0;
    localparam logic [7:0] Lead4 = 8'hF0;
    localparam logic [7:0] ContMark = 8'h80;

    // encode length thresholds
    localparam logic [CodeWidth-1:0] Limit1 = 21'h00080;
    localparam logic [CodeWidth-1:0] Limit2 = 21'h00800;
    localparam logic [CodeWidth-1:0] Limit3 = 21'h10000;

    // one result of the transcoder
    typedef struct packed {
        logic [CodeWidth-1:0] value;
        logic                 last;
        logic                 error;
    } result_t;

endpackage

// File: hw/rtl/utf8tc_enc.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8tc_enc
// Encode byte selector: given a code point, the room and the byte index,
// produce that UTF-8 byte, or the room error result.
// ----------------------------------------------------------------------------
module utf8tc_enc
(
    input  logic [utf8tc_pkg::CodeWidth-1:0] code,
    input  logic [utf8tc_pkg::RoomWidth-1:0] room,
    input  logic [1:0]                       idx,
    output utf8tc_pkg::result_t              res
);
    import utf8tc_pkg::*;

    logic [2:0] len;
    logic [1:0] len_m1;
    logic [1:0] sh;
    logic [5:0] chunk;
    logic [7:0] lead;
    logic [7:0] byte_val;
    logic       short_room;

    always_comb
    begin
        if (code < Limit1)
        begin
            len = 3'd1;
        end
        else if (code < Limit2)
        begin
            len = 3'd2;
        end
        else if (code < Limit3)
        begin
            len = 3'd3;
        end
        else
        begin
            len = 3'd4;
        end
    end

    assign len_m1     = 2'(len - 3'd1);
    assign sh         = 2'(len_m1 - idx);
    assign short_room = (room < len);

    // six-bit group of the code point that this byte carries
    always_comb
    begin
        case (sh)
            2'd0:    chunk = code[5:0];
            2'd1:    chunk = code[11:6];
            2'd2:    chunk = code[17:12];
            default: chunk = {3'b000, code[20:18]};
        endcase
    end

    always_comb
    begin
        case (len)
            3'd2:    lead = Lead2;
            3'd3:    lead = Lead3;
            default: lead = Lead4;
        endcase
    end

    assign byte_val = (idx == 2'd0) ? (lead | {2'b00, chunk}) : (ContMark | {2'b00, chunk});

    always_comb
    begin
        if (short_room)
        begin
            res.value = '0;
            res.last  = 1'b1;
            res.error = 1'b1;
        end
        else if (len == 3'd1)
        begin
            res.value = code;
            res.last  = 1'b1;
            res.error = 1'b0;
        end
        else
        begin
            res.value = {13'd0, byte_val};
            res.last  = (idx == len_m1);
            res.error = 1'b0;
        end
    end

endmodule

// File: hw/rtl/utf8_transcoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_transcoder
// UTF-8 transcoder: decodes bytes to code points or encodes code points to
// one to four bytes, direction chosen by a mode register.
//
//   channel  | handshake                      | payload
//   ---------+--------------------------------+--------------------------
//   input    | in_valid / in_ready            | in_value, room
//   output   | out_valid / out_ready          | out_value, last, error
//   config   | psel, penable, pwrite, pready  | paddr, pwdata, prdata
//
// An accepted item sits in an input register; one result per cycle moves to
// the output register while it is free. Decode takes one byte per item;
// encode emits one to four bytes per code point, or one error result. The
// input register reloads in the cycle its item finishes, and the output
// register reloads in the cycle its result is taken, so neither side idles.
// Reset clears the valid flags, the direction and the partial sequence.
// ----------------------------------------------------------------------------
module utf8_transcoder
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [utf8tc_pkg::CodeWidth-1:0]  in_value,
    input  logic [utf8tc_pkg::RoomWidth-1:0]  room,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [utf8tc_pkg::CodeWidth-1:0]  out_value,
    output logic                              last,
    output logic                              error,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [2:0]                        paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready
);
    import utf8tc_pkg::*;

    logic                 direction_reg;
    logic [1:0]           rem_reg, rem_next;
    logic [CodeWidth-1:0] part_reg, part_next;

    logic                 s1_valid_reg;
    logic [CodeWidth-1:0] s1_value_reg;
    logic [RoomWidth-1:0] s1_room_reg;
    logic [1:0]           s1_idx_reg;

    logic                 out_valid_reg;
    result_t              out_reg;

    logic                 cfg_write;
    logic                 out_free;
    logic                 s1_done;
    logic                 emit;
    logic                 dec_emit;
    logic [7:0]           dec_byte;
    result_t              enc_res;
    result_t              dec_res;
    result_t              res_sel;

    // configuration port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign prdata    = (paddr[2] == RegDirection) ? {31'd0, direction_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            direction_reg <= DirDecode;
        end
        else if (cfg_write && (paddr[2] == RegDirection))
        begin
            direction_reg <= pwdata[0];
        end
    end

    // decode step
    assign dec_byte = s1_value_reg[7:0];

    always_comb
    begin
        rem_next  = rem_reg;
        part_next = part_reg;
        dec_emit  = 1'b0;
        dec_res.value = '0;
        dec_res.last  = 1'b1;
        dec_res.error = 1'b0;
        if (rem_reg != 2'd0)
        begin
            // shift in the continuation payload, top bits unchecked
            part_next = {part_reg[CodeWidth-7:0], dec_byte[5:0]};
            rem_next  = rem_reg - 2'd1;
            dec_emit  = (rem_reg == 2'd1);
            dec_res.value = part_next;
        end
        else if (!dec_byte[7])
        begin
            dec_emit      = 1'b1;
            dec_res.value = {13'd0, dec_byte};
        end
        else if (dec_byte[7:5] == 3'b110)
        begin
            part_next = {16'd0, dec_byte[4:0]};
            rem_next  = 2'd1;
        end
        else if (dec_byte[7:4] == 4'b1110)
        begin
            part_next = {17'd0, dec_byte[3:0]};
            rem_next  = 2'd2;
        end
        else
        begin
            part_next = {18'd0, dec_byte[2:0]};
            rem_next  = 2'd3;
        end
    end

    utf8tc_enc u_enc
    (
        .code (s1_value_reg),
        .room (s1_room_reg),
        .idx  (s1_idx_reg),
        .res  (enc_res)
    );

    assign out_free = !out_valid_reg || out_ready;
    assign res_sel  = (direction_reg == DirEncode) ? enc_res : dec_res;

    always_comb
    begin
        if (direction_reg == DirEncode)
        begin
            emit    = s1_valid_reg && out_free;
            s1_done = emit && enc_res.last;
        end
        else
        begin
            emit    = s1_valid_reg && out_free && dec_emit;
            s1_done = s1_valid_reg && (out_free || !dec_emit);
        end
    end

    assign in_ready = !s1_valid_reg || s1_done;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s1_idx_reg   <= 2'd0;
        end
        else
        begin
            if (in_ready)
            begin
                s1_valid_reg <= in_valid;
            end
            if (s1_done)
            begin
                s1_idx_reg <= 2'd0;
            end
            else if (emit)
            begin
                s1_idx_reg <= s1_idx_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            s1_value_reg <= in_value;
            s1_room_reg  <= room;
        end
    end

    // decode sequence state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg  <= 2'd0;
            part_reg <= '0;
        end
        else if (cfg_write && (paddr[2] == RegDirection))
        begin
            rem_reg  <= 2'd0;
            part_reg <= '0;
        end
        else if (s1_done && (direction_reg == DirDecode))
        begin
            rem_reg  <= rem_next;
            part_reg <= part_next;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_reg <= res_sel;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_value = out_reg.value;
    assign last      = out_reg.last;
    assign error     = out_reg.error;

    // checks
    a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && error |-> last && (out_value == '0))
        else $error("error result without last or with nonzero value");

    a_dec_single: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (direction_reg == DirDecode) |-> last && !error)
        else $error("decode result must be single and error free");

    a_cfg_clear: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_write && (paddr[2] == RegDirection) |=> (rem_reg == 2'd0) && (part_reg == '0))
        else $error("direction write did not clear partial sequence");

    a_idx_reset: assert property (@(posedge clk) disable iff (!rst_n)
        s1_done |=> (s1_idx_reg == 2'd0))
        else $error("byte index not rewound after item");

endmodule

// File: tb/tb_utf8_transcoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_utf8_transcoder
// Self-checking bench for the UTF-8 transcoder. A scoreboard follows the
// decode state and the direction register and predicts every result. The
// bench runs directed byte and code point cases, a long output stall, and
// random traffic in both directions under several idle and stall mixes.
// ----------------------------------------------------------------------------
module tb_utf8_transcoder;
    import utf8tc_pkg::*;

    localparam int SettleCycles = 6;
    localparam int IdleLimit = 1000;
    localparam int HoldCycles = 200;
    localparam int MaxPrinted = 40;
    localparam logic [2:0] DirectionAddr = {RegDirection, 2'b00};

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_ready;
    logic [CodeWidth-1:0] in_value;
    logic [RoomWidth-1:0] room;
    logic                 out_valid;
    logic                 out_ready;
    logic [CodeWidth-1:0] out_value;
    logic                 last;
    logic                 error;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [2:0]           paddr;
    logic [31:0]          pwdata;
    logic [31:0]          prdata;
    logic                 pready;

    // scoreboard state
    logic                 mode;
    logic [1:0]           cont_left;
    logic [CodeWidth-1:0] cp_accum;
    result_t              due_results[$];
    int                   mismatches;
    int                   tx_idle_pct;
    int                   rx_stall_pct;
    int                   hold_request;
    int                   idle_cycles;

    utf8_transcoder dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_value  (in_value),
        .room      (room),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_value (out_value),
        .last      (last),
        .error     (error),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    task automatic report_mismatch(input string field, input int unsigned got,
                                   input int unsigned want);
        if (mismatches < MaxPrinted)
            $display("%0t mismatch on %s: got 0x%0h, want 0x%0h", $realtime, field, got, want);
        mismatches++;
    endtask

    function automatic void expect_result(input logic [CodeWidth-1:0] v, input logic l,
                                          input logic e);
        result_t r;
        r.value = v;
        r.last  = l;
        r.error = e;
        due_results.push_back(r);
    endfunction

    // Work out the results of one accepted transaction and advance the state.
    function automatic void predict_transcode(input logic [CodeWidth-1:0] v,
                                              input logic [RoomWidth-1:0] r);
        logic [7:0] b;
        logic [7:0] lead;
        int         len;
        int         sh;
        b = v[7:0];
        if (mode == DirDecode)
        begin
            if (cont_left != 2'd0)
            begin
                // any byte counts as a continuation here
                cp_accum  = {cp_accum[CodeWidth-7:0], b[5:0]};
                cont_left = cont_left - 2'd1;
                if (cont_left == 2'd0)
                    expect_result(cp_accum, 1'b1, 1'b0);
            end
            else if (b < ContMark)
                expect_result(CodeWidth'(b), 1'b1, 1'b0);
            else if ((b & 8'hE0) == Lead2)
            begin
                cp_accum  = CodeWidth'(b & 8'h1F);
                cont_left = 2'd1;
            end
            else if ((b & 8'hF0) == Lead3)
            begin
                cp_accum  = CodeWidth'(b & 8'h0F);
                cont_left = 2'd2;
            end
            else
            begin
                // stray continuations and 0xF8..0xFF start a four-byte run too
                cp_accum  = CodeWidth'(b & 8'h07);
                cont_left = 2'd3;
            end
        end
        else
        begin
            if (v < Limit1)
                len = 1;
            else if (v < Limit2)
                len = 2;
            else if (v < Limit3)
                len = 3;
            else
                len = 4;
            if (int'(r) < len)
                expect_result('0, 1'b1, 1'b1);
            else if (len == 1)
                expect_result(v, 1'b1, 1'b0);
            else
            begin
                lead = (len == 2) ? Lead2 : (len == 3) ? Lead3 : Lead4;
                sh = 6 * (len - 1);
                expect_result(CodeWidth'(lead | 8'(v >> sh)), 1'b0, 1'b0);
                for (int i = 1; i < len; i++)
                begin
                    sh = 6 * (len - 1 - i);
                    expect_result(CodeWidth'(ContMark | {2'b00, 6'(v >> sh)}),
                                  (i == len - 1), 1'b0);
                end
            end
        end
    endfunction

    // Offer one transaction; valid is left high so the next one follows at once.
    task automatic send_item(input logic [CodeWidth-1:0] v, input logic [RoomWidth-1:0] r);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_value <= v;
        room     <= r;
        do @(posedge clk); while (!in_ready);
        predict_transcode(v, r);
    endtask

    // Decode ignores the upper bits and room, so fill them with junk.
    task automatic send_byte(input logic [7:0] b);
        send_item({13'($urandom), b}, RoomWidth'($urandom));
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        while (due_results.size() != 0)
            @(posedge clk);
        // let a byte that produces nothing leave the input register
        repeat (SettleCycles) @(posedge clk);
    endtask

    task automatic write_direction(input logic dir);
        drain_results();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= DirectionAddr;
        pwdata  <= 32'(dir);
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        mode      = dir;
        cont_left = '0;
        cp_accum  = '0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if (prdata !== 32'(dir))
            report_mismatch("prdata", prdata, 32'(dir));
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic test_decode_directed();
        write_direction(DirDecode);
        send_byte(8'h00);
        send_byte(8'h7F);
        // two-byte run whose second byte is not a continuation
        send_byte(8'hC3);
        send_byte(8'h41);
        send_byte(8'hE2);
        send_byte(8'h82);
        send_byte(8'hAC);
        send_byte(8'hF0);
        send_byte(8'h9F);
        send_byte(8'h98);
        send_byte(8'h80);
        // stray continuation acts as a four-byte lead
        send_byte(8'h80);
        send_byte(8'h41);
        send_byte(8'hFF);
        send_byte(8'h80);
        // rewrite the same direction mid-run: the partial run must drop
        send_byte(8'hFF);
        write_direction(DirDecode);
        send_byte(8'h41);
    endtask

    task automatic test_encode_directed();
        write_direction(DirEncode);
        send_item(21'h00000, 3'd0);
        send_item(21'h0007F, 3'd1);
        send_item(21'h00080, 3'd1);
        send_item(21'h007FF, 3'd2);
        send_item(21'h00800, 3'd2);
        send_item(21'h0FFFF, 3'd7);
        send_item(21'h10000, 3'd3);
        send_item(21'h10FFFF, 3'd4);
        send_item(21'h1FFFFF, 3'd5);
        send_item(21'h0D800, 3'd6);
    endtask

    // Hold the output long enough that the block backs up into its input.
    task automatic test_stall_pressure();
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        write_direction(DirEncode);
        hold_request = HoldCycles;
        for (int i = 0; i < 24; i++)
            send_item(CodeWidth'($urandom_range(32'h10000, 32'h1FFFFF)), 3'd4);
        drain_results();
    endtask

    task automatic run_random_decode(input int count);
        int         sent;
        int         pick;
        int         seq_len;
        logic [7:0] b;
        sent = 0;
        while (sent < count)
        begin
            pick = $urandom_range(99);
            seq_len = $urandom_range(1, 4);
            if (pick < 12)
            begin
                send_byte(8'($urandom));
                sent++;
            end
            else
            begin
                case (seq_len)
                    1: b = {1'b0, 7'($urandom)};
                    2: b = {3'b110, 5'($urandom)};
                    3: b = {4'b1110, 4'($urandom)};
                    default: b = {5'b11110, 3'($urandom)};
                endcase
                send_byte(b);
                sent++;
                // cut some runs short so the next lead is swallowed
                if (pick < 22)
                    seq_len = $urandom_range(1, seq_len);
                for (int i = 1; i < seq_len; i++)
                begin
                    send_byte({2'b10, 6'($urandom)});
                    sent++;
                end
            end
        end
    endtask

    task automatic run_random_encode(input int count);
        int                   pick;
        logic [CodeWidth-1:0] cp;
        logic [RoomWidth-1:0] r;
        for (int n = 0; n < count; n++)
        begin
            pick = $urandom_range(99);
            if (pick < 20)
                cp = CodeWidth'($urandom_range(0, 32'h7F));
            else if (pick < 40)
                cp = CodeWidth'($urandom_range(32'h80, 32'h7FF));
            else if (pick < 60)
                cp = CodeWidth'($urandom_range(32'h800, 32'hFFFF));
            else if (pick < 80)
                cp = CodeWidth'($urandom_range(32'h10000, 32'h10FFFF));
            else if (pick < 90)
                cp = CodeWidth'($urandom_range(32'h110000, 32'h1FFFFF));
            else
            begin
                case ($urandom_range(5))
                    0: cp = Limit1 - 1'b1;
                    1: cp = Limit1;
                    2: cp = Limit2 - 1'b1;
                    3: cp = Limit2;
                    4: cp = Limit3 - 1'b1;
                    default: cp = Limit3;
                endcase
            end
            if ($urandom_range(99) < 75)
                r = RoomWidth'($urandom_range(4, 7));
            else
                r = RoomWidth'($urandom_range(0, 3));
            send_item(cp, r);
        end
    endtask

    task automatic test_random_traffic();
        int tx_mix[4] = '{0, 56, 0, 15};
        int rx_mix[4] = '{0, 0, 56, 15};
        for (int p = 0; p < 4; p++)
        begin
            write_direction(DirDecode);
            tx_idle_pct  = tx_mix[p];
            rx_stall_pct = rx_mix[p];
            run_random_decode(52);
            write_direction(DirEncode);
            run_random_encode(52);
        end
    endtask

    // receiver: random stalls, plus a long hold when one is requested
    initial
    begin
        int hold_left;
        hold_left = 0;
        out_ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_left == 0 && hold_request != 0)
            begin
                hold_left = hold_request;
                hold_request = 0;
            end
            if (hold_left != 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    always @(posedge clk)
    begin : check_results
        result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (due_results.size() == 0)
                report_mismatch("unexpected result", out_value, 0);
            else
            begin
                want = due_results.pop_front();
                if (out_value !== want.value)
                    report_mismatch("out_value", out_value, want.value);
                if (last !== want.last)
                    report_mismatch("last", last, want.last);
                if (error !== want.error)
                    report_mismatch("error", error, want.error);
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || psel)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IdleLimit)
        begin
            $display("status: fail");
            $finish;
        end
    end

    initial
    begin
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        in_value     = '0;
        room         = '0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        mode         = DirDecode;
        cont_left    = '0;
        cp_accum     = '0;
        mismatches   = 0;
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        hold_request = 0;
        idle_cycles  = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_decode_directed();
        test_encode_directed();
        test_stall_pressure();
        test_random_traffic();
        drain_results();

        if (due_results.size() != 0)
            report_mismatch("missing results", due_results.size(), 0);
        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// File: filelist.f
hw/rtl/utf8tc_pkg.sv
hw/rtl/utf8tc_enc.sv
hw/rtl/utf8_transcoder.sv
tb/tb_utf8_transcoder.sv
